/* hdl/ppp_pkg.sv */
// Shared constants, codes and types of the pinhole point projection core.
package ppp_pkg;

   localparam int MAX_CAMERAS_DEF = 16;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int SLOT_LIMIT      = 16;
   localparam int ENTRIES         = 12;
   localparam int COEF_W          = 32;
   localparam int SUM_W           = 64;
   localparam int INT_BITS        = 41;
   localparam int FRAC_BITS       = 17;
   localparam int Q_BITS          = INT_BITS + FRAC_BITS;
   localparam int ROW_LAT         = 2;
   localparam int DIV_LAT         = Q_BITS + 1;

   localparam logic ACT_LOAD    = 1'b0;
   localparam logic ACT_PROJECT = 1'b1;

   localparam logic [2:0] CSR_NUM_CAMERAS  = 3'd0;
   localparam logic [2:0] CSR_OFFSET_X     = 3'd1;
   localparam logic [2:0] CSR_OFFSET_Y     = 3'd2;
   localparam logic [2:0] CSR_IMAGE_WIDTH  = 3'd3;
   localparam logic [2:0] CSR_IMAGE_HEIGHT = 3'd4;

   localparam logic [1:0] STAT_INSIDE  = 2'd0;
   localparam logic [1:0] STAT_OUTSIDE = 2'd1;
   localparam logic [1:0] STAT_ZERO    = 2'd2;

   typedef struct packed {
      logic       valid;
      logic [3:0] camera;
      logic       last;
   } side_type;

   typedef struct packed {
      logic [Q_BITS-1:0] quot;
      logic              neg;
      logic              ovf;
      logic              zero;
   } div_out_type;

endpackage

/* hdl/pinhole_point_projection_core.sv */
// Top level: camera table, issue control, row products, dividers and output stages.
//
// Usage:
//  req_ channel: action 0 loads one coefficient (slot, entry) of a 3x4 camera
//  matrix; action 1 projects a point through every camera in use.
//  rsp_ channel: one item per camera in use, in camera order, last set on the
//  final one. A project item with a camera count of zero yields nothing.
//  csr_ port: plain register writes, done while the block is idle.
//  Throughput: one result per cycle unless rsp_stall holds the output. A project
//  item stalls the input until the single camera issue counter has issued every
//  camera in use, reading one camera's twelve coefficients from twelve table
//  RAMs per cycle while the pipeline advances.
//  Path to the first result: one table read, the two product/sum stages, the
//  59-stage divider and three output stages.
//  Reset clears control state and the registers to their defaults; the table
//  holds garbage until written. When rsp_stall holds a valid result the whole
//  pipeline freezes and req_stall rises; nothing is lost or repeated.
module pinhole_point_projection_core #(
   parameter int MAX_CAMERAS = ppp_pkg::MAX_CAMERAS_DEF,
   parameter int COORD_WIDTH = ppp_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic [3:0]                    req_camera_slot,
   input  logic [3:0]                    req_entry,
   input  logic signed [31:0]            req_coefficient,
   input  logic signed [31:0]            req_point_x,
   input  logic signed [31:0]            req_point_y,
   input  logic signed [31:0]            req_point_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [3:0]                    rsp_camera,
   output logic signed [COORD_WIDTH-1:0] rsp_image_x,
   output logic signed [COORD_WIDTH-1:0] rsp_image_y,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_last,
   input  logic                          csr_wr_en,
   input  logic [2:0]                    csr_index,
   input  logic [31:0]                   csr_wr_data
);
   import ppp_pkg::*;

   localparam int CAM_DEPTH = (MAX_CAMERAS < SLOT_LIMIT) ? MAX_CAMERAS : SLOT_LIMIT;
   localparam int CAM_AW    = (CAM_DEPTH > 1) ? $clog2(CAM_DEPTH) : 1;
   localparam int SIDE_LEN  = 1 + ROW_LAT + DIV_LAT + 2;
   localparam int VAL_W     = Q_BITS + 2;
   localparam int OFS_W     = VAL_W + 1;
   localparam int CMP_W     = ((COORD_WIDTH > 32) ? COORD_WIDTH : 32) + 1;
   localparam logic signed [OFS_W-1:0] SAT_HI = (OFS_W'(1) <<< (COORD_WIDTH - 1)) - OFS_W'(1);
   localparam logic signed [OFS_W-1:0] SAT_LO = -SAT_HI - OFS_W'(1);

   // configuration
   logic [4:0]         num_cameras_ff;
   logic signed [31:0] offset_x_ff, offset_y_ff;
   logic [30:0]        image_width_ff, image_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cameras_ff  <= 5'd1;
         offset_x_ff     <= '0;
         offset_y_ff     <= '0;
         image_width_ff  <= '0;
         image_height_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_NUM_CAMERAS:  num_cameras_ff  <= csr_wr_data[4:0];
            CSR_OFFSET_X:     offset_x_ff     <= csr_wr_data;
            CSR_OFFSET_Y:     offset_y_ff     <= csr_wr_data;
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wr_data[30:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wr_data[30:0];
            default: ;
         endcase
      end
   end

   // pipeline advance
   logic adv;
   logic rsp_valid_ff;
   assign adv = !rsp_valid_ff || !rsp_stall;

   // issue control
   logic        busy_ff, busy_in;
   logic [3:0]  cam_ff, cam_in;
   logic [4:0]  n_ff, n_in;
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic [4:0]  n_clamp;
   logic        accept, issue_last, load_we;

   assign n_clamp   = (num_cameras_ff > 5'(CAM_DEPTH)) ? 5'(CAM_DEPTH) : num_cameras_ff;
   assign req_stall = busy_ff || !adv;
   assign accept    = req_valid && !req_stall;
   assign issue_last = ({1'b0, cam_ff} + 5'd1) == n_ff;
   assign load_we   = accept && (req_action == ACT_LOAD) &&
                      ({1'b0, req_camera_slot} < 5'(CAM_DEPTH)) &&
                      (req_entry < 4'(ENTRIES));

   always_comb begin
      busy_in = busy_ff;
      cam_in  = cam_ff;
      n_in    = n_ff;
      if (busy_ff && adv) begin
         if (issue_last) begin
            busy_in = 1'b0;
         end else begin
            cam_in = cam_ff + 4'd1;
         end
      end else if (accept && req_action == ACT_PROJECT && n_clamp != 5'd0) begin
         busy_in = 1'b1;
         cam_in  = '0;
         n_in    = n_clamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cam_ff  <= '0;
         n_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         cam_ff  <= cam_in;
         n_ff    <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_action == ACT_PROJECT) begin
         px_ff <= req_point_x;
         py_ff <= req_point_y;
         pz_ff <= req_point_z;
      end
   end

   // camera table: one RAM per matrix entry
   logic [31:0] coef [ENTRIES];
   for (genvar e = 0; e < ENTRIES; e++) begin : g_tab
      ppp_ram #(.WIDTH(COEF_W), .DEPTH(CAM_DEPTH)) u_ram (
         .clock   (clock),
         .wr_en   (load_we && (req_entry == 4'(e))),
         .wr_addr (req_camera_slot[CAM_AW-1:0]),
         .wr_data (req_coefficient),
         .rd_en   (adv),
         .rd_addr (cam_ff[CAM_AW-1:0]),
         .rd_data (coef[e])
      );
   end

   // point aligned with table read data
   logic signed [31:0] rpx_ff, rpy_ff, rpz_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         rpx_ff <= px_ff;
         rpy_ff <= py_ff;
         rpz_ff <= pz_ff;
      end
   end

   // side information travels beside the data
   side_type side_ff [SIDE_LEN];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SIDE_LEN; i++) begin
            side_ff[i] <= '0;
         end
      end else if (adv) begin
         side_ff[0].valid  <= busy_ff;
         side_ff[0].camera <= cam_ff;
         side_ff[0].last   <= issue_last;
         for (int i = 1; i < SIDE_LEN; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // rows
   logic signed [SUM_W-1:0] sx, sy, sw;
   ppp_row u_row_x (
      .clock(clock), .adv(adv),
      .coef0(coef[0]), .coef1(coef[1]), .coef2(coef[2]), .coef3(coef[3]),
      .px(rpx_ff), .py(rpy_ff), .pz(rpz_ff), .row_sum(sx)
   );
   ppp_row u_row_y (
      .clock(clock), .adv(adv),
      .coef0(coef[4]), .coef1(coef[5]), .coef2(coef[6]), .coef3(coef[7]),
      .px(rpx_ff), .py(rpy_ff), .pz(rpz_ff), .row_sum(sy)
   );
   ppp_row u_row_w (
      .clock(clock), .adv(adv),
      .coef0(coef[8]), .coef1(coef[9]), .coef2(coef[10]), .coef3(coef[11]),
      .px(rpx_ff), .py(rpy_ff), .pz(rpz_ff), .row_sum(sw)
   );

   // dividers
   div_out_type dx, dy;
   ppp_div u_div_x (.clock(clock), .adv(adv), .num(sx), .den(sw), .res(dx));
   ppp_div u_div_y (.clock(clock), .adv(adv), .num(sy), .den(sw), .res(dy));

   // stage A: round and apply sign
   logic signed [VAL_W-1:0] vx_ff, vy_ff;
   logic                    ovx_ff, ovy_ff, ngx_ff, ngy_ff, za_ff;
   logic [Q_BITS:0]         rx, ry;

   assign rx = {1'b0, dx.quot} + (Q_BITS + 1)'(1);
   assign ry = {1'b0, dy.quot} + (Q_BITS + 1)'(1);

   always_ff @(posedge clock) begin
      if (adv) begin
         vx_ff  <= dx.neg ? -$signed({2'b0, rx[Q_BITS:1]}) : $signed({2'b0, rx[Q_BITS:1]});
         vy_ff  <= dy.neg ? -$signed({2'b0, ry[Q_BITS:1]}) : $signed({2'b0, ry[Q_BITS:1]});
         ovx_ff <= dx.ovf;
         ovy_ff <= dy.ovf;
         ngx_ff <= dx.neg;
         ngy_ff <= dy.neg;
         za_ff  <= dx.zero;
      end
   end

   // stage B: add offset and saturate
   logic signed [OFS_W-1:0]       ax, ay;
   logic signed [COORD_WIDTH-1:0] bx_ff, by_ff, bx_in, by_in;
   logic                          zb_ff;

   assign ax = OFS_W'(vx_ff) + OFS_W'(offset_x_ff);
   assign ay = OFS_W'(vy_ff) + OFS_W'(offset_y_ff);

   always_comb begin
      if (ovx_ff) begin
         bx_in = ngx_ff ? SAT_LO[COORD_WIDTH-1:0] : SAT_HI[COORD_WIDTH-1:0];
      end else if (ax > SAT_HI) begin
         bx_in = SAT_HI[COORD_WIDTH-1:0];
      end else if (ax < SAT_LO) begin
         bx_in = SAT_LO[COORD_WIDTH-1:0];
      end else begin
         bx_in = ax[COORD_WIDTH-1:0];
      end
      if (ovy_ff) begin
         by_in = ngy_ff ? SAT_LO[COORD_WIDTH-1:0] : SAT_HI[COORD_WIDTH-1:0];
      end else if (ay > SAT_HI) begin
         by_in = SAT_HI[COORD_WIDTH-1:0];
      end else if (ay < SAT_LO) begin
         by_in = SAT_LO[COORD_WIDTH-1:0];
      end else begin
         by_in = ay[COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bx_ff <= bx_in;
         by_ff <= by_in;
         zb_ff <= za_ff;
      end
   end

   // output register: bounds test
   logic signed [CMP_W-1:0] cx, cy, cw, ch;
   logic                    outside;
   logic [1:0]              status_in;
   logic [3:0]              rsp_camera_ff;
   logic signed [COORD_WIDTH-1:0] rsp_x_ff, rsp_y_ff;
   logic [1:0]              rsp_status_ff;
   logic                    rsp_last_ff;

   assign cx = CMP_W'(bx_ff);
   assign cy = CMP_W'(by_ff);
   assign cw = $signed(CMP_W'(image_width_ff));
   assign ch = $signed(CMP_W'(image_height_ff));
   assign outside = (cx < 0) || (cx > cw) || (cy < 0) || (cy > ch);
   assign status_in = zb_ff ? STAT_ZERO : (outside ? STAT_OUTSIDE : STAT_INSIDE);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= side_ff[SIDE_LEN-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_camera_ff <= side_ff[SIDE_LEN-1].camera;
         rsp_last_ff   <= side_ff[SIDE_LEN-1].last;
         rsp_x_ff      <= zb_ff ? '0 : bx_ff;
         rsp_y_ff      <= zb_ff ? '0 : by_ff;
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_camera  = rsp_camera_ff;
   assign rsp_image_x = rsp_x_ff;
   assign rsp_image_y = rsp_y_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_last    = rsp_last_ff;
endmodule

/* hdl/ppp_ram.sv */
// Generic single write port RAM with registered read.
module ppp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* hdl/ppp_row.sv */
// One matrix row times the homogeneous point: product stage then sum stage.
module ppp_row (
   input  logic                    clock,
   input  logic                    adv,
   input  logic signed [31:0]      coef0,
   input  logic signed [31:0]      coef1,
   input  logic signed [31:0]      coef2,
   input  logic signed [31:0]      coef3,
   input  logic signed [31:0]      px,
   input  logic signed [31:0]      py,
   input  logic signed [31:0]      pz,
   output logic signed [63:0]      row_sum
);
   import ppp_pkg::*;

   logic signed [SUM_W-1:0] p0_ff, p1_ff, p2_ff, c3_ff;
   logic signed [SUM_W-1:0] sum_ff, sum_in;

   assign sum_in = (p0_ff >>> 1) + (p1_ff >>> 1) + (p2_ff >>> 1) + c3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_ff  <= coef0 * px;
         p1_ff  <= coef1 * py;
         p2_ff  <= coef2 * pz;
         c3_ff  <= {{17{coef3[31]}}, coef3, 15'b0};
         sum_ff <= sum_in;
      end
   end

   assign row_sum = sum_ff;
endmodule

/* hdl/ppp_div.sv */
// Pipelined restoring divider, one quotient bit per stage, Q41.16 plus a round bit.
module ppp_div (
   input  logic                    clock,
   input  logic                    adv,
   input  logic signed [63:0]      num,
   input  logic signed [63:0]      den,
   output ppp_pkg::div_out_type    res
);
   import ppp_pkg::*;

   logic [SUM_W-1:0]    un, ud;
   logic [SUM_W-1:0]    r_ff   [Q_BITS+1];
   logic [SUM_W-1:0]    ud_ff  [Q_BITS+1];
   logic [INT_BITS-1:0] dl_ff  [Q_BITS+1];
   logic [Q_BITS-1:0]   q_ff   [Q_BITS+1];
   logic                neg_ff [Q_BITS+1];
   logic                ovf_ff [Q_BITS+1];
   logic                zero_ff[Q_BITS+1];

   assign un = num[63] ? (~num + 64'd1) : num;
   assign ud = den[63] ? (~den + 64'd1) : den;

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff[0]    <= un >> INT_BITS;
         ud_ff[0]   <= ud;
         dl_ff[0]   <= un[INT_BITS-1:0];
         q_ff[0]    <= '0;
         neg_ff[0]  <= num[63] ^ den[63];
         ovf_ff[0]  <= (un >> INT_BITS) >= ud;
         zero_ff[0] <= (den == '0);
      end
   end

   for (genvar k = 1; k <= Q_BITS; k++) begin : g_step
      logic [SUM_W:0]   r2;
      logic             ge;
      logic [SUM_W:0]   diff;
      assign r2   = {r_ff[k-1], dl_ff[k-1][INT_BITS-1]};
      assign ge   = r2 >= {1'b0, ud_ff[k-1]};
      assign diff = r2 - {1'b0, ud_ff[k-1]};
      always_ff @(posedge clock) begin
         if (adv) begin
            r_ff[k]    <= ge ? diff[SUM_W-1:0] : r2[SUM_W-1:0];
            ud_ff[k]   <= ud_ff[k-1];
            dl_ff[k]   <= {dl_ff[k-1][INT_BITS-2:0], 1'b0};
            q_ff[k]    <= {q_ff[k-1][Q_BITS-2:0], ge};
            neg_ff[k]  <= neg_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
         end
      end
   end

   assign res.quot = q_ff[Q_BITS];
   assign res.neg  = neg_ff[Q_BITS];
   assign res.ovf  = ovf_ff[Q_BITS];
   assign res.zero = zero_ff[Q_BITS];
endmodule
